// File: hw/rtl/box_query_block_counter_unit_assert.svh
// ----------------------------------------------------------------------------
// Box query block counter: assertion macros
// Concurrent check wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BOX_QUERY_BLOCK_COUNTER_UNIT_ASSERT_SVH
`define BOX_QUERY_BLOCK_COUNTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is applied
`define BQBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bqbc check failed");
// next-cycle implication, disabled while reset is applied
`define BQBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bqbc check failed");
`else
`define BQBC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BQBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/bqbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box query block counter package
// Shared widths, constants, register map, structs and the saturating add.
// ----------------------------------------------------------------------------
package bqbc_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int LEVEL_W = 3;
	localparam int CNT_W   = 21;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;

	// algorithm constants
	localparam int WINDOW_RADIUS = 3;
	localparam int LEVELS        = 5;
	localparam int MAX_POINTS    = 1048576;

	localparam int FLAG_BITS = 2 * WINDOW_RADIUS;
	localparam int SEEN_W    = $clog2(WINDOW_RADIUS + 1);
	localparam int INC_W     = $clog2(WINDOW_RADIUS + 2);

	// classification queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register map (index = byte address / 4)
	typedef enum logic [2:0] {
		REG_BOX_X_LOW   = 3'd0,
		REG_BOX_X_HIGH  = 3'd1,
		REG_BOX_Y_LOW   = 3'd2,
		REG_BOX_Y_HIGH  = 3'd3,
		REG_QUERY_MODE  = 3'd4,
		REG_QUERY_LEVEL = 3'd5
	} reg_idx_t;

	// query modes
	localparam logic MODE_ALL_LEVELS   = 1'b0;
	localparam logic MODE_SINGLE_LEVEL = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x_low;
		logic [COORD_W-1:0] x_high;
		logic [COORD_W-1:0] y_low;
		logic [COORD_W-1:0] y_high;
		logic               mode;
		logic [LEVEL_W-1:0] level;
	} cfg_t;

	// classified point as it travels from front to back
	typedef struct packed {
		logic hit;
		logic last;
	} q_entry_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	// add a small increment and clamp at MAX_POINTS
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
		input logic [INC_W-1:0] n);
		logic [CNT_W:0] sum;
		sum = {1'b0, v} + (CNT_W + 1)'(n);
		if (sum >= (CNT_W + 1)'(MAX_POINTS)) begin
			return CNT_W'(MAX_POINTS);
		end
		return sum[CNT_W-1:0];
	endfunction

endpackage

// File: hw/rtl/box_query_block_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box query block counter
// Counts points inside a query box and points near a match for one pass.
// ----------------------------------------------------------------------------
// Points are taken one per clock cycle, continuously, while out_stall stays
// low. Each point is classified as it is accepted and queued; the counting
// back end takes one queued point per cycle, unless a pass-ending point
// meets a held result, and updates its match window and counters in that
// same cycle. The pass result and out_valid are registered as the is_last
// point leaves the queue. A held result stalls only the pass-ending point
// in the two-entry queue; the input stalls once that queue is full.
// Register writes over the APB port belong between passes.
`include "box_query_block_counter_unit_assert.svh"

module box_query_block_counter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bqbc_pkg::ADDR_W-1:0]  paddr,
	input  logic [bqbc_pkg::DATA_W-1:0]  pwdata,
	output logic [bqbc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// point stream
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bqbc_pkg::COORD_W-1:0] point_x,
	input  logic [bqbc_pkg::COORD_W-1:0] point_y,
	input  logic [bqbc_pkg::LEVEL_W-1:0] point_level,
	input  logic                         is_last,
	// pass results
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bqbc_pkg::CNT_W-1:0]   match_count,
	output logic [bqbc_pkg::CNT_W-1:0]   block_count
);

	bqbc_pkg::cfg_t      cfg;
	bqbc_pkg::q_status_t q_status;
	bqbc_pkg::q_entry_t  push_entry;
	bqbc_pkg::q_entry_t  head;
	logic                push;
	logic                pop;

	bqbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bqbc_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_level (point_level),
		.is_last     (is_last),
		.cfg         (cfg),
		.q_status    (q_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	bqbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	bqbc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.match_count (match_count),
		.block_count (block_count)
	);

	// a new result follows only from a pass-ending point leaving the queue
	`BQBC_ASSERT_NOW(a_result_from_last, clk, arst_n, $rose(out_valid), $past(pop && head.last))
	// every match lies in its own window, so blocks never trail matches
	`BQBC_ASSERT_NOW(a_blocks_cover_matches, clk, arst_n, out_valid, block_count >= match_count)
	// results stay within the saturation limit
	`BQBC_ASSERT_NOW(a_counts_saturate, clk, arst_n, out_valid, 32'(match_count) <= bqbc_pkg::MAX_POINTS && 32'(block_count) <= bqbc_pkg::MAX_POINTS)
	// queue occupancy never passes its depth
	`BQBC_ASSERT_NOW(a_queue_bound, clk, arst_n, push || pop || !push, 32'(q_status.count) <= bqbc_pkg::QUEUE_DEPTH)

endmodule

// File: hw/rtl/bqbc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box query configuration registers
// APB-style register file holding the query box, mode and level.
// ----------------------------------------------------------------------------
module bqbc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bqbc_pkg::ADDR_W-1:0] paddr,
	input  logic [bqbc_pkg::DATA_W-1:0] pwdata,
	output logic [bqbc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output bqbc_pkg::cfg_t             cfg
);

	bqbc_pkg::cfg_t      cfg_q;
	bqbc_pkg::reg_idx_t  idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = bqbc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// write on the access phase of a transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low  <= '0;
			cfg_q.x_high <= '1;
			cfg_q.y_low  <= '0;
			cfg_q.y_high <= '1;
			cfg_q.mode   <= bqbc_pkg::MODE_ALL_LEVELS;
			cfg_q.level  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				bqbc_pkg::REG_BOX_X_LOW:   cfg_q.x_low  <= pwdata[bqbc_pkg::COORD_W-1:0];
				bqbc_pkg::REG_BOX_X_HIGH:  cfg_q.x_high <= pwdata[bqbc_pkg::COORD_W-1:0];
				bqbc_pkg::REG_BOX_Y_LOW:   cfg_q.y_low  <= pwdata[bqbc_pkg::COORD_W-1:0];
				bqbc_pkg::REG_BOX_Y_HIGH:  cfg_q.y_high <= pwdata[bqbc_pkg::COORD_W-1:0];
				bqbc_pkg::REG_QUERY_MODE:  cfg_q.mode   <= pwdata[0];
				bqbc_pkg::REG_QUERY_LEVEL: cfg_q.level  <= pwdata[bqbc_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			bqbc_pkg::REG_BOX_X_LOW:   prdata = bqbc_pkg::DATA_W'(cfg_q.x_low);
			bqbc_pkg::REG_BOX_X_HIGH:  prdata = bqbc_pkg::DATA_W'(cfg_q.x_high);
			bqbc_pkg::REG_BOX_Y_LOW:   prdata = bqbc_pkg::DATA_W'(cfg_q.y_low);
			bqbc_pkg::REG_BOX_Y_HIGH:  prdata = bqbc_pkg::DATA_W'(cfg_q.y_high);
			bqbc_pkg::REG_QUERY_MODE:  prdata = bqbc_pkg::DATA_W'(cfg_q.mode);
			bqbc_pkg::REG_QUERY_LEVEL: prdata = bqbc_pkg::DATA_W'(cfg_q.level);
			default:                   prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/bqbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box query front end
// Accepts points and marks each one a hit when its level is valid and selected and it lies inside the box.
// ----------------------------------------------------------------------------
module bqbc_front (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bqbc_pkg::COORD_W-1:0] point_x,
	input  logic [bqbc_pkg::COORD_W-1:0] point_y,
	input  logic [bqbc_pkg::LEVEL_W-1:0] point_level,
	input  logic                         is_last,
	input  bqbc_pkg::cfg_t               cfg,
	input  bqbc_pkg::q_status_t          q_status,
	output logic                         push,
	output bqbc_pkg::q_entry_t           push_entry
);

	logic                         level_ok;
	logic                         level_sel;
	logic [bqbc_pkg::COORD_W-1:0] cx;
	logic [bqbc_pkg::COORD_W-1:0] cy;
	logic                         in_box;

	// hold the source while the queue is full
	assign in_stall = q_status.full;
	assign push     = in_valid && !in_stall;

	// level filter and coordinate scaling
	always_comb begin
		level_ok  = 32'(point_level) < bqbc_pkg::LEVELS;
		level_sel = (cfg.mode == bqbc_pkg::MODE_ALL_LEVELS) || (point_level == cfg.level);
		if (cfg.mode == bqbc_pkg::MODE_ALL_LEVELS) begin
			cx = point_x >> point_level;
			cy = point_y >> point_level;
		end else begin
			cx = point_x;
			cy = point_y;
		end
	end

	// inclusive box test
	assign in_box = (cx >= cfg.x_low) && (cx <= cfg.x_high) &&
	                (cy >= cfg.y_low) && (cy <= cfg.y_high);

	assign push_entry.hit  = level_ok && level_sel && in_box;
	assign push_entry.last = is_last;

endmodule

// File: hw/rtl/bqbc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box query classification queue
// Short FIFO of classified points between front end and counting back end.
// ----------------------------------------------------------------------------
module bqbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bqbc_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output bqbc_pkg::q_entry_t  head,
	output bqbc_pkg::q_status_t status
);

	bqbc_pkg::q_entry_t              entries_q [bqbc_pkg::QUEUE_DEPTH];
	logic [bqbc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bqbc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bqbc_pkg::QCNT_W-1:0]     count_q;

	function automatic logic [bqbc_pkg::QPTR_W-1:0] ptr_next(
		input logic [bqbc_pkg::QPTR_W-1:0] p);
		if (32'(p) == bqbc_pkg::QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign head         = entries_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (32'(count_q) == bqbc_pkg::QUEUE_DEPTH);

	// store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/bqbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box query back end
// Tracks the match window, counts matches and accessed blocks, and holds
// the per-pass result until it is taken.
// ----------------------------------------------------------------------------
module bqbc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bqbc_pkg::q_entry_t          head,
	input  bqbc_pkg::q_status_t         q_status,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bqbc_pkg::CNT_W-1:0]  match_count,
	output logic [bqbc_pkg::CNT_W-1:0]  block_count
);

	logic [bqbc_pkg::FLAG_BITS-1:0]     flags_q;
	logic [bqbc_pkg::SEEN_W-1:0]        seen_q;
	logic [bqbc_pkg::CNT_W-1:0]         match_cnt_q;
	logic [bqbc_pkg::CNT_W-1:0]         block_cnt_q;
	logic                               out_valid_q;
	logic [bqbc_pkg::CNT_W-1:0]         match_count_q;
	logic [bqbc_pkg::CNT_W-1:0]         block_count_q;

	logic                               out_free;
	logic                               full_hit;
	logic [bqbc_pkg::WINDOW_RADIUS-1:0] tail_hit;
	logic [bqbc_pkg::INC_W-1:0]         block_inc;
	logic [bqbc_pkg::CNT_W-1:0]         match_next;
	logic [bqbc_pkg::CNT_W-1:0]         block_next;

	assign out_valid   = out_valid_q;
	assign match_count = match_count_q;
	assign block_count = block_count_q;

	// take a point unless it closes a pass and the result slot is held under out_stall
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !q_status.empty && (!head.last || out_free);

	// settle blocks: the point a full radius back, plus clipped tail on pass end
	always_comb begin
		full_hit = (32'(seen_q) >= bqbc_pkg::WINDOW_RADIUS) && (head.hit || (flags_q != '0));
		for (int k = 0; k < bqbc_pkg::WINDOW_RADIUS; k++) begin
			tail_hit[k] = (32'(seen_q) >= k) && (head.hit ||
				((flags_q & bqbc_pkg::FLAG_BITS'((1 << (k + bqbc_pkg::WINDOW_RADIUS)) - 1))
				 != '0));
		end
		block_inc = bqbc_pkg::INC_W'(full_hit);
		if (head.last) begin
			for (int k = 0; k < bqbc_pkg::WINDOW_RADIUS; k++) begin
				block_inc = block_inc + bqbc_pkg::INC_W'(tail_hit[k]);
			end
		end
		match_next = bqbc_pkg::sat_add(match_cnt_q, bqbc_pkg::INC_W'(head.hit));
		block_next = bqbc_pkg::sat_add(block_cnt_q, block_inc);
	end

	// pass state: shift window, count, clear on pass end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			seen_q      <= '0;
			match_cnt_q <= '0;
			block_cnt_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				flags_q     <= '0;
				seen_q      <= '0;
				match_cnt_q <= '0;
				block_cnt_q <= '0;
			end else begin
				flags_q     <= {flags_q[bqbc_pkg::FLAG_BITS-2:0], head.hit};
				match_cnt_q <= match_next;
				block_cnt_q <= block_next;
				if (32'(seen_q) < bqbc_pkg::WINDOW_RADIUS) begin
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			match_count_q <= match_next;
			block_count_q <= block_next;
		end
	end

endmodule
